// ===== src/assert_macros.svh =====
// Assertion macros used by the running median top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

// ===== src/rmh_pkg.sv =====
// Shared constants and helpers of the running median histogram block.
`timescale 1ns / 1ps
package rmh_pkg;

  localparam int VALUE_RANGE = 1024;
  localparam int MAX_KEPT    = 65535;
  localparam int COUNT_LIMIT = 65535;

  localparam int SAMPLE_W = 11;
  localparam int MED_W    = 11;
  localparam int CNT_W    = 16;
  localparam int BIN_W    = $clog2(VALUE_RANGE);

  // Samples stored at most.
  localparam logic [CNT_W-1:0] CAPACITY =
    CNT_W'((MAX_KEPT < COUNT_LIMIT) ? MAX_KEPT : COUNT_LIMIT);

  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(VALUE_RANGE - 1);

  // Map a positive sample to its bin, saturating at the top bin.
  function automatic logic [BIN_W-1:0] bin_index(input logic [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-2:0] mag;
    mag = s[SAMPLE_W-2:0];
    if (int'(mag) >= VALUE_RANGE) begin
      return LAST_BIN;
    end
    return BIN_W'(mag);
  endfunction

endpackage

// ===== src/rmh_if.sv =====
// Handshake interfaces for the sample and result channels.
`timescale 1ns / 1ps
interface sample_if import rmh_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface result_if import rmh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MED_W-1:0] median_doubled;
  logic [CNT_W-1:0] kept_count;
  logic             store_full;

  modport source (output valid, output median_doubled, output kept_count,
                  output store_full, input ready);
  modport sink (input valid, input median_doubled, input kept_count,
                input store_full, output ready);
endinterface

// ===== src/rmh_bin_ram.sv =====
// Single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module rmh_bin_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/running_median_histogram.sv =====
// Top level: running median of positive samples over a bin histogram.
`timescale 1ns / 1ps
// Running median over a histogram of positive samples. Each request carries
// one signed sample; samples of zero or below are dropped with no result.
// A positive sample increments its bin in a 1024-entry RAM, then the bins
// are walked upward through the RAM's single read port until the middle
// rank(s) are found; the result is twice the median plus the kept count.
// Once the store holds 65535 samples further samples are not stored and the
// result flags store_full. The bin walk reads one bin per cycle.
// After reset the block clears every RAM entry before it accepts its first
// request. A sample is taken only while the block is idle. A finished result
// waits in an output register while the next request is taken.
`include "assert_macros.svh"
module running_median_histogram import rmh_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  sample_if.sink        samples,
  result_if.source      results
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INC,
    S_WALK,
    S_OUT
  } state_t;

  state_t             state;
  logic [BIN_W-1:0]   clr_idx;
  logic [BIN_W-1:0]   bin_idx;
  logic [CNT_W-1:0]   total_kept;
  logic               full_flag;
  logic [BIN_W:0]     walk_idx;
  logic [BIN_W-1:0]   data_idx;
  logic               data_vld;
  logic [CNT_W-1:0]   cum;
  logic [CNT_W-1:0]   rank_lo;
  logic [CNT_W-1:0]   rank_hi;
  logic               lo_found;
  logic [BIN_W-1:0]   lo_val;
  logic [BIN_W-1:0]   hi_val;

  logic               mem_we;
  logic [BIN_W-1:0]   mem_waddr;
  logic [CNT_W-1:0]   mem_wdata;
  logic [BIN_W-1:0]   mem_raddr;
  logic [CNT_W-1:0]   mem_rdata;

  logic               accept;
  logic               positive;
  logic               walk_issue;
  logic [CNT_W-1:0]   cum_sum;
  logic               lo_hit;
  logic               hi_hit;
  logic [CNT_W-1:0]   walk_count;
  logic               out_free;

  rmh_bin_ram #(
    .DEPTH (VALUE_RANGE),
    .WIDTH (CNT_W)
  ) u_bins (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign samples.ready = (state == S_IDLE);
  assign accept        = samples.valid && samples.ready;
  assign positive      = !samples.sample[SAMPLE_W-1] && (samples.sample != '0);
  assign out_free      = !results.valid || results.ready;

  // Drive RAM ports: clear sweep, read-modify-write, bin walk
  always_comb begin
    mem_we    = (state == S_CLEAR) || (state == S_INC);
    mem_waddr = (state == S_CLEAR) ? clr_idx : bin_idx;
    mem_wdata = (state == S_CLEAR) ? '0 : mem_rdata + CNT_W'(1);
    mem_raddr = (state == S_IDLE) ? bin_index(samples.sample)
                                  : walk_idx[BIN_W-1:0];
  end

  // Walk arithmetic on the bin just read
  always_comb begin
    walk_issue = (state == S_WALK) && (walk_idx < (BIN_W+1)'(VALUE_RANGE));
    cum_sum    = cum + mem_rdata;
    lo_hit     = data_vld && !lo_found &&
                 ((cum_sum > rank_lo) || (data_idx == LAST_BIN));
    hi_hit     = data_vld && ((cum_sum > rank_hi) || (data_idx == LAST_BIN));
    walk_count = (state == S_INC) ? total_kept + CNT_W'(1) : total_kept;
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_idx       <= '0;
      total_kept    <= '0;
      data_vld      <= 1'b0;
      lo_found      <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      // Raise the result when loaded, drop it once taken
      if ((state == S_OUT) && out_free) begin
        results.valid <= 1'b1;
      end else if (results.valid && results.ready) begin
        results.valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + BIN_W'(1);
          if (clr_idx == LAST_BIN) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (accept && positive) begin
            bin_idx   <= bin_index(samples.sample);
            full_flag <= (total_kept >= CAPACITY);
            if (total_kept >= CAPACITY) begin
              rank_lo  <= (walk_count - CNT_W'(1)) >> 1;
              rank_hi  <= walk_count >> 1;
              walk_idx <= '0;
              data_vld <= 1'b0;
              cum      <= '0;
              lo_found <= 1'b0;
              state    <= S_WALK;
            end else begin
              state <= S_INC;
            end
          end
        end

        S_INC: begin
          total_kept <= walk_count;
          rank_lo    <= (walk_count - CNT_W'(1)) >> 1;
          rank_hi    <= walk_count >> 1;
          walk_idx   <= '0;
          data_vld   <= 1'b0;
          cum        <= '0;
          lo_found   <= 1'b0;
          state      <= S_WALK;
        end

        S_WALK: begin
          // Advance the read pointer, track the data coming back
          if (walk_issue) begin
            walk_idx <= walk_idx + (BIN_W+1)'(1);
          end
          data_vld <= walk_issue && !hi_hit;
          data_idx <= walk_idx[BIN_W-1:0];
          if (data_vld) begin
            cum <= cum_sum;
          end
          if (lo_hit) begin
            lo_val   <= data_idx;
            lo_found <= 1'b1;
          end
          if (hi_hit) begin
            hi_val <= data_idx;
            state  <= S_OUT;
          end
        end

        S_OUT: begin
          if (out_free) begin
            results.median_doubled <= MED_W'(lo_val) + MED_W'(hi_val);
            results.kept_count     <= total_kept;
            results.store_full     <= full_flag;
            state                  <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NEVER(a_kept_cap, clk, rst, total_kept > CAPACITY, "kept count above capacity")
  `ASSERT_CLK(a_full_at_cap, clk, rst, (results.valid && results.store_full) |-> (total_kept == CAPACITY), "store_full result while below capacity")
  `ASSERT_CLK(a_lo_le_hi, clk, rst, (state == S_OUT) |-> (lo_found && (lo_val <= hi_val)), "lower middle bin above upper")
  `ASSERT_CLK(a_cum_bound, clk, rst, (state == S_WALK) |-> (cum <= total_kept), "bin walk sum exceeds kept count")
  `ASSERT_CLK(a_inc_bumps, clk, rst, (state == S_INC) |=> (total_kept == $past(total_kept) + CNT_W'(1)), "kept count not advanced on store")

endmodule
